/* hdl/taz_pkg.sv */
// ---------------------------------------------------------------------------
// taz_pkg
// Shared types and constants for the tilt averaging zoom angle block.
// ---------------------------------------------------------------------------
package taz_pkg;

	// Operation codes carried in s_tuser
	localparam logic [1:0] OP_ADD     = 2'd0;
	localparam logic [1:0] OP_COMPUTE = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// Result status codes carried in m_tuser
	localparam logic [1:0] STAT_NONE     = 2'd0;
	localparam logic [1:0] STAT_BASELINE = 2'd1;
	localparam logic [1:0] STAT_ANGLES   = 2'd2;

	// Field widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned LIMIT_W  = 10;
	localparam int unsigned ANGLE_W  = 9;
	localparam int unsigned PITCH_W  = 11;
	localparam int unsigned MAG_W    = 11;

	// Scaling: dev * ANGLE_SCALE / (depth * Q_ONE)
	localparam int unsigned ANGLE_SCALE = 420;
	localparam int unsigned Q_ONE       = 4096;
	localparam int unsigned ANGLE_BOUND = 200;
	localparam logic [LIMIT_W-1:0] PITCH_LIMIT_RST = 10'd200;

	localparam int unsigned RING_DEPTH_DEF = 32;

	// Sequencing strobes from the top level to each axis lane
	typedef struct packed {
		logic acc_clr;
		logic acc_en;
		logic base_ld;
		logic start;
	} lane_ctl_t;

endpackage

/* hdl/taz_ram.sv */
// ---------------------------------------------------------------------------
// taz_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module taz_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/taz_lane.sv */
// ---------------------------------------------------------------------------
// taz_lane
// One axis lane: window accumulator, baseline, deviation scaling through a
// reciprocal multiply by the window divisor, and symmetric clamp.
// ---------------------------------------------------------------------------
module taz_lane #(
	parameter int unsigned RING_DEPTH = taz_pkg::RING_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  taz_pkg::lane_ctl_t                  ctl,
	input  logic signed [taz_pkg::SAMPLE_W-1:0] sample,
	input  logic [taz_pkg::LIMIT_W-1:0]         bound,
	output logic signed [taz_pkg::MAG_W-1:0]    value,
	output logic                                done
);

	localparam int unsigned SW  = taz_pkg::SAMPLE_W + $clog2(RING_DEPTH);
	localparam int unsigned DW  = SW + 1;
	localparam int unsigned PW  = DW + $clog2(taz_pkg::ANGLE_SCALE);
	localparam int unsigned QSH = $clog2(taz_pkg::Q_ONE);
	localparam int unsigned HW  = PW - QSH;
	localparam int unsigned QW  = taz_pkg::MAG_W - 1;
	localparam int unsigned NW  = QW + $clog2(RING_DEPTH);
	localparam int unsigned RSH = NW + $clog2(RING_DEPTH);
	localparam int unsigned RW  = NW + 1;
	localparam int unsigned XW  = NW + RW;
	// ceil(2^RSH / depth): exact floor division for any NW-bit numerator
	localparam longint unsigned RECIP_L =
		((64'd1 << RSH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
	localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
	localparam logic [HW-1:0] SAT_NUM = HW'(RING_DEPTH << QW);
	localparam logic [taz_pkg::MAG_W-1:0] MAG_SAT = taz_pkg::MAG_W'(1 << QW);

	typedef enum logic [1:0] {
		L_IDLE,
		L_MUL,
		L_DIV,
		L_CLAMP
	} phase_t;

	phase_t                         phase_q;
	logic signed [SW-1:0]           acc_q;
	logic signed [SW-1:0]           base_q;
	logic signed [DW-1:0]           diff_s1;
	logic                           neg_q;
	logic [PW-1:0]                  prod_q;
	logic                           sat_q;
	logic [QW-1:0]                  quo_q;
	logic signed [taz_pkg::MAG_W-1:0] value_q;
	logic                           done_q;

	logic [DW-1:0]                  abs_diff;
	logic [HW-1:0]                  scaled;
	logic                           over;
	logic [XW-1:0]                  rprod;
	logic [taz_pkg::MAG_W-1:0]      mag;
	logic [taz_pkg::MAG_W-1:0]      bound_ext;
	logic [taz_pkg::MAG_W-1:0]      clamped;

	// Magnitude of the deviation, split divide: shift by Q_ONE, then by depth
	assign abs_diff  = diff_s1[DW-1] ? (~diff_s1 + DW'(1)) : diff_s1;
	assign scaled    = prod_q[PW-1:QSH];
	assign over      = (scaled >= SAT_NUM);
	assign rprod     = XW'(scaled[NW-1:0]) * XW'(RECIP);
	assign mag       = sat_q ? MAG_SAT : {1'b0, quo_q};
	assign bound_ext = taz_pkg::MAG_W'(bound);
	assign clamped   = (mag > bound_ext) ? bound_ext : mag;

	// Accumulate the window and hold the baseline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			base_q <= '0;
		end else begin
			if (ctl.acc_clr) begin
				acc_q <= '0;
			end else if (ctl.acc_en) begin
				acc_q <= acc_q + SW'(sample);
			end
			if (ctl.base_ld) begin
				base_q <= acc_q;
			end
		end
	end

	// Scale sequencer: difference, multiply, divide, clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= L_IDLE;
			diff_s1 <= '0;
			neg_q   <= 1'b0;
			prod_q  <= '0;
			sat_q   <= 1'b0;
			quo_q   <= '0;
			value_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				L_IDLE: begin
					if (ctl.start) begin
						diff_s1 <= DW'(acc_q) - DW'(base_q);
						phase_q <= L_MUL;
					end
				end
				L_MUL: begin
					neg_q   <= diff_s1[DW-1];
					prod_q  <= PW'(abs_diff) * PW'(taz_pkg::ANGLE_SCALE);
					phase_q <= L_DIV;
				end
				L_DIV: begin
					sat_q   <= over;
					quo_q   <= rprod[RSH +: QW];
					phase_q <= L_CLAMP;
				end
				L_CLAMP: begin
					value_q <= neg_q ? -$signed(clamped) : $signed(clamped);
					done_q  <= 1'b1;
					phase_q <= L_IDLE;
				end
				default: begin
					phase_q <= L_IDLE;
				end
			endcase
		end
	end

	assign value = value_q;
	assign done  = done_q;

	// A clamp always follows the divide step
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == L_CLAMP) |-> ($past(phase_q) == L_DIV))
		else $error("lane clamp entered without a finished divide");

endmodule

/* hdl/tilt_average_zoom_angles_top.sv */
// ---------------------------------------------------------------------------
// tilt_average_zoom_angles_top
// Ring of accelerometer samples with baseline capture and clamped tilt
// angles for the zoom view.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel takes one operation per transfer (s_tuser): add sample,
//   compute angles or restart. Add and restart produce no output; every
//   compute produces exactly one m_* transfer whose m_tuser is the status.
//   cfg_* writes pitch_limit (reset 200); cfg_ready is always high.
// Sequence:
//   Add, restart and unused codes finish in S_IDLE and may follow back to
//   back. A compute that is not ready or not zoomed passes through S_EMIT
//   into the output register. A full compute reads the ring one entry per
//   cycle through the single RAM read port, then a baseline capture goes
//   through S_EMIT to the output register. Otherwise the x and y lanes
//   scale side by side (multiply, divide, clamp), then the result is merged
//   in S_WAIT and loaded into the output register from S_EMIT.
//   One item is in work at a time.
// Reset:
//   Clears write index, full and baseline flags and the output valid flag.
//   The ring is not cleared; a compute only reads it after a full wrap.
// Stall:
//   A finished result sits in the output register until m_tready; new
//   items are still accepted meanwhile, and the next result waits its turn.
// ---------------------------------------------------------------------------
module tilt_average_zoom_angles_top #(
	parameter int unsigned RING_DEPTH = taz_pkg::RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // accel_x[15:0], accel_y[31:16], zoomed_in[32], zero pad
	input  logic [1:0]  s_tuser,  // operation[1:0]
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // zoom_angle[8:0], zoom_pitch[19:9], zero pad
	output logic [1:0]  m_tuser,  // status[1:0]
	// Configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data  // pitch_limit
);

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam int unsigned CW = $clog2(RING_DEPTH + 1);
	localparam int unsigned SMW = taz_pkg::SAMPLE_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
	localparam logic [CW-1:0] CNT_END = CW'(RING_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SUM,
		S_WAIT,
		S_EMIT
	} state_t;

	state_t                              state_q;
	logic [AW-1:0]                       wr_idx_q;
	logic                                full_q;
	logic                                based_q;
	logic [CW-1:0]                       rd_cnt_q;
	logic                                rd_vld_s1;
	logic [taz_pkg::LIMIT_W-1:0]         pitch_limit_q;
	logic [1:0]                          res_status_q;
	logic signed [taz_pkg::ANGLE_W-1:0]  res_angle_q;
	logic signed [taz_pkg::PITCH_W-1:0]  res_pitch_q;
	logic                                m_tvalid_q;
	logic [23:0]                         m_tdata_q;
	logic [1:0]                          m_tuser_q;

	logic                                in_xfer;
	logic [1:0]                          op;
	logic                                zoomed;
	logic                                wr_en;
	logic                                rd_en;
	logic                                sum_done;
	logic                                out_load;
	logic [2*SMW-1:0]                    rd_data;
	taz_pkg::lane_ctl_t                  lane_ctl;
	logic signed [taz_pkg::MAG_W-1:0]    val_x;
	logic signed [taz_pkg::MAG_W-1:0]    val_y;
	logic                                done_x;
	logic                                done_y;

	// Input decode
	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign op       = s_tuser;
	assign zoomed   = s_tdata[2*SMW];
	assign wr_en    = in_xfer && (op == taz_pkg::OP_ADD);

	// Ring read sweep
	assign rd_en    = (state_q == S_SUM) && (rd_cnt_q != CNT_END);
	assign sum_done = (state_q == S_SUM) && (rd_cnt_q == CNT_END) && !rd_vld_s1;

	// Output register takes the pending result when it is empty or drains
	assign out_load = (state_q == S_EMIT) && (!m_tvalid_q || m_tready);

	// Lane strobes
	always_comb begin
		lane_ctl         = '0;
		lane_ctl.acc_clr = in_xfer && (op == taz_pkg::OP_COMPUTE);
		lane_ctl.acc_en  = rd_vld_s1;
		lane_ctl.base_ld = sum_done && !based_q;
		lane_ctl.start   = sum_done && based_q;
	end

	taz_ram #(
		.WIDTH (2 * SMW),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx_q),
		.wr_data ({s_tdata[2*SMW-1:SMW], s_tdata[SMW-1:0]}),
		.rd_en   (rd_en),
		.rd_addr (rd_cnt_q[AW-1:0]),
		.rd_data (rd_data)
	);

	taz_lane #(
		.RING_DEPTH (RING_DEPTH)
	) u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.sample ($signed(rd_data[SMW-1:0])),
		.bound  (taz_pkg::LIMIT_W'(taz_pkg::ANGLE_BOUND)),
		.value  (val_x),
		.done   (done_x)
	);

	taz_lane #(
		.RING_DEPTH (RING_DEPTH)
	) u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.sample ($signed(rd_data[2*SMW-1:SMW])),
		.bound  (pitch_limit_q),
		.value  (val_y),
		.done   (done_y)
	);

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_limit_q <= taz_pkg::PITCH_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			pitch_limit_q <= cfg_data;
		end
	end

	// Control sequence, ring flags, merge of lane results and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wr_idx_q   <= '0;
			full_q     <= 1'b0;
			based_q    <= 1'b0;
			rd_cnt_q   <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						case (op)
							taz_pkg::OP_ADD: begin
								if (wr_idx_q == LAST_IDX) begin
									wr_idx_q <= '0;
									full_q   <= 1'b1;
								end else begin
									wr_idx_q <= wr_idx_q + AW'(1);
								end
							end
							taz_pkg::OP_RESTART: begin
								wr_idx_q <= '0;
								full_q   <= 1'b0;
								based_q  <= 1'b0;
							end
							taz_pkg::OP_COMPUTE: begin
								if (full_q && zoomed) begin
									rd_cnt_q <= '0;
									state_q  <= S_SUM;
								end else begin
									res_status_q <= taz_pkg::STAT_NONE;
									res_angle_q  <= '0;
									res_pitch_q  <= '0;
									state_q      <= S_EMIT;
								end
							end
							default: begin
								// unused code: drop
							end
						endcase
					end
				end
				S_SUM: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CW'(1);
					end
					if (sum_done) begin
						if (based_q) begin
							state_q <= S_WAIT;
						end else begin
							based_q      <= 1'b1;
							res_status_q <= taz_pkg::STAT_BASELINE;
							res_angle_q  <= '0;
							res_pitch_q  <= '0;
							state_q      <= S_EMIT;
						end
					end
				end
				S_WAIT: begin
					if (done_x) begin
						res_status_q <= taz_pkg::STAT_ANGLES;
						res_angle_q  <= val_x[taz_pkg::ANGLE_W-1:0];
						res_pitch_q  <= val_y;
						state_q      <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						m_tuser_q  <= res_status_q;
						m_tdata_q  <= {4'b0, res_pitch_q, res_angle_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// The window sweep only runs over a ring that has wrapped
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> full_q)
		else $error("ring read sweep on a ring that is not full");

	// Both lanes finish together, and only while the sequence waits for them
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_x || done_y) |-> (done_x && done_y && state_q == S_WAIT))
		else $error("lane completion out of step");

	// Only an angles result carries nonzero angle and pitch
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && res_status_q != taz_pkg::STAT_ANGLES)
		|-> (res_angle_q == '0 && res_pitch_q == '0))
		else $error("nonzero angle or pitch on a status without angles");

endmodule
